@@ hdl/acd_pkg.sv @@
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types and constants of the ASCII line command decoder: character
// codes, command kinds, line records passed from parser to executor, limits.
// ----------------------------------------------------------------------------
package acd_pkg;

   localparam int MAG_W   = 16;
   localparam int VALUE_W = 10;
   localparam int KIND_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [MAG_W-1:0]   MAG_SAT = 16'hFFFF;
   localparam logic [VALUE_W-1:0] FAN_MAX = 10'd255;

   // Depth of the record queue between parser and executor
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
   localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
   localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
   localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;
   localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
   localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
   localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;

   localparam logic [CSR_IDX_W-1:0] CSR_SOLDER_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOLDER_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOTAIR_MIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOTAIR_MAX = 2'd3;

   localparam logic [VALUE_W-1:0] SOLDER_MIN_RST = 10'd200;
   localparam logic [VALUE_W-1:0] SOLDER_MAX_RST = 10'd450;
   localparam logic [VALUE_W-1:0] HOTAIR_MIN_RST = 10'd100;
   localparam logic [VALUE_W-1:0] HOTAIR_MAX_RST = 10'd500;

   typedef enum logic [KIND_W-1:0] {
      KIND_SOLDER  = 3'd0,
      KIND_HOTAIR  = 3'd1,
      KIND_FAN     = 3'd2,
      KIND_POWER   = 3'd3,
      KIND_BOOST   = 3'd4,
      KIND_STATION = 3'd5,
      KIND_STATUS  = 3'd6,
      KIND_PING    = 3'd7
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic             negative;
      logic [MAG_W-1:0] magnitude;
   } line_rec_type;

   typedef struct packed {
      logic [VALUE_W-1:0] solder_min;
      logic [VALUE_W-1:0] solder_max;
      logic [VALUE_W-1:0] hotair_min;
      logic [VALUE_W-1:0] hotair_max;
   } limits_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

@@ hdl/acd_front.sv @@
// ----------------------------------------------------------------------------
// acd_front
// Byte parser: tracks line position, command letter and argument digits and
// pushes one record per well-formed command line at the newline.
// ----------------------------------------------------------------------------
module acd_front
   import acd_pkg::*;
#(
   parameter int LINE_CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [BYTE_W-1:0]  rx_byte,
   output logic               push,
   output line_rec_type       push_rec
);

   localparam int CNT_W = $clog2(LINE_CAPACITY);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);

   typedef enum logic [3:0] {
      PH_EMPTY  = 4'b0001,
      PH_LETTER = 4'b0010,
      PH_ARG    = 4'b0100,
      PH_BAD    = 4'b1000
   } line_phase_type;

   typedef enum logic [3:0] {
      NUM_BLANKS = 4'b0001,
      NUM_SIGN   = 4'b0010,
      NUM_DIGITS = 4'b0100,
      NUM_DONE   = 4'b1000
   } num_phase_type;

   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0] letter_ff, letter_in;
   line_phase_type    line_phase_ff, line_phase_in;
   logic              closed_ff, closed_in;
   num_phase_type     num_phase_ff, num_phase_in;
   logic              negative_ff, negative_in;
   logic [MAG_W-1:0]  magnitude_ff, magnitude_in;

   logic              is_digit;
   logic              is_blank;
   logic [MAG_W+3:0]  mag_next;
   logic              emit;
   logic              needs_arg;
   cmd_kind_type      kind;

   assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                     (rx_byte == CH_VT) || (rx_byte == CH_FF);
   assign mag_next = ({4'b0, magnitude_ff} << 3) + ({4'b0, magnitude_ff} << 1) +
                     (MAG_W+4)'(rx_byte - CH_ZERO);

   always_comb begin
      emit      = 1'b1;
      needs_arg = 1'b1;
      kind      = KIND_SOLDER;
      case (letter_ff)
         CH_T: kind = KIND_SOLDER;
         CH_H: kind = KIND_HOTAIR;
         CH_F: kind = KIND_FAN;
         CH_P: kind = KIND_POWER;
         CH_M: kind = KIND_STATION;
         CH_B: begin
            kind      = KIND_BOOST;
            needs_arg = 1'b0;
         end
         CH_S: begin
            kind      = KIND_STATUS;
            needs_arg = 1'b0;
         end
         CH_Z: begin
            kind      = KIND_PING;
            needs_arg = 1'b0;
         end
         default: emit = 1'b0;
      endcase
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      letter_in     = letter_ff;
      line_phase_in = line_phase_ff;
      closed_in     = closed_ff;
      num_phase_in  = num_phase_ff;
      negative_in   = negative_ff;
      magnitude_in  = magnitude_ff;
      push          = 1'b0;
      push_rec.kind      = kind;
      push_rec.negative  = negative_ff;
      push_rec.magnitude = magnitude_ff;

      if (accept) begin
         if ((rx_byte == CH_LF) || (byte_count_ff == CNT_LAST)) begin
            if (rx_byte == CH_LF) begin
               push = emit && ((line_phase_ff == PH_ARG) ||
                               ((line_phase_ff == PH_LETTER) && !needs_arg));
            end
            byte_count_in = '0;
            letter_in     = '0;
            line_phase_in = PH_EMPTY;
            closed_in     = 1'b0;
            num_phase_in  = NUM_BLANKS;
            negative_in   = 1'b0;
            magnitude_in  = '0;
         end else begin
            byte_count_in = byte_count_ff + 1'b1;
            if (!closed_ff) begin
               if ((rx_byte == CH_CR) || (rx_byte == CH_NUL)) begin
                  closed_in = 1'b1;
               end else if (byte_count_ff == '0) begin
                  letter_in     = rx_byte;
                  line_phase_in = PH_LETTER;
               end else if (byte_count_ff == CNT_W'(1)) begin
                  if (line_phase_ff == PH_LETTER) begin
                     line_phase_in = (rx_byte == CH_COLON) ? PH_ARG : PH_BAD;
                  end
               end else if (line_phase_ff == PH_ARG) begin
                  case (num_phase_ff)
                     NUM_BLANKS: begin
                        if (!is_blank) begin
                           if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
                              negative_in  = (rx_byte == CH_MINUS);
                              num_phase_in = NUM_SIGN;
                           end else if (is_digit) begin
                              magnitude_in = (mag_next > (MAG_W+4)'(MAG_SAT)) ?
                                             MAG_SAT : mag_next[MAG_W-1:0];
                              num_phase_in = NUM_DIGITS;
                           end else begin
                              num_phase_in = NUM_DONE;
                           end
                        end
                     end
                     NUM_SIGN, NUM_DIGITS: begin
                        if (is_digit) begin
                           magnitude_in = (mag_next > (MAG_W+4)'(MAG_SAT)) ?
                                          MAG_SAT : mag_next[MAG_W-1:0];
                           num_phase_in = NUM_DIGITS;
                        end else begin
                           num_phase_in = NUM_DONE;
                        end
                     end
                     default: num_phase_in = num_phase_ff;
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         letter_ff     <= '0;
         line_phase_ff <= PH_EMPTY;
         closed_ff     <= 1'b0;
         num_phase_ff  <= NUM_BLANKS;
         negative_ff   <= 1'b0;
         magnitude_ff  <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         letter_ff     <= letter_in;
         line_phase_ff <= line_phase_in;
         closed_ff     <= closed_in;
         num_phase_ff  <= num_phase_in;
         negative_ff   <= negative_in;
         magnitude_ff  <= magnitude_in;
      end
   end

endmodule

@@ hdl/acd_queue.sv @@
// ----------------------------------------------------------------------------
// acd_queue
// Short first-in first-out queue of line records between parser and executor.
// ----------------------------------------------------------------------------
module acd_queue
   import acd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  line_rec_type     push_rec,
   input  logic             pop,
   output queue_status_type status,
   output line_rec_type     head_rec
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   line_rec_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head_rec         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/acd_back.sv @@
// ----------------------------------------------------------------------------
// acd_back
// Command executor: clamps or flags the argument of each queued record and
// holds the finished result in the output register until it is taken.
// ----------------------------------------------------------------------------
module acd_back
   import acd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rec_valid,
   input  line_rec_type       rec,
   input  limits_type         limits,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_command_kind,
   output logic [VALUE_W-1:0] rsp_command_value,
   output logic               rsp_marks_activity
);

   logic               valid_ff, valid_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               activity_ff, activity_in;

   logic               mag_nonzero;
   logic               is_negative;
   logic [VALUE_W-1:0] lo;
   logic [VALUE_W-1:0] hi;
   logic [VALUE_W-1:0] clamped;

   assign mag_nonzero = (rec.magnitude != '0);
   assign is_negative = rec.negative && mag_nonzero;

   always_comb begin
      lo = '0;
      hi = FAN_MAX;
      case (rec.kind)
         KIND_SOLDER: begin
            lo = limits.solder_min;
            hi = limits.solder_max;
         end
         KIND_HOTAIR: begin
            lo = limits.hotair_min;
            hi = limits.hotair_max;
         end
         default: begin
            lo = '0;
            hi = FAN_MAX;
         end
      endcase
   end

   always_comb begin
      if (is_negative || (rec.magnitude < MAG_W'(lo))) begin
         clamped = lo;
      end else if (rec.magnitude > MAG_W'(hi)) begin
         clamped = hi;
      end else begin
         clamped = rec.magnitude[VALUE_W-1:0];
      end
   end

   always_comb begin
      value_in    = '0;
      activity_in = 1'b0;
      case (rec.kind)
         KIND_SOLDER, KIND_HOTAIR, KIND_FAN: begin
            value_in    = clamped;
            activity_in = 1'b1;
         end
         KIND_POWER: begin
            value_in    = VALUE_W'(mag_nonzero);
            activity_in = 1'b1;
         end
         KIND_BOOST: activity_in = 1'b1;
         KIND_STATION: value_in = VALUE_W'(mag_nonzero);
         default: begin
            value_in    = '0;
            activity_in = 1'b0;
         end
      endcase
   end

   assign pop      = rec_valid && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff     <= rec.kind;
         value_ff    <= value_in;
         activity_ff <= activity_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_command_kind   = kind_ff;
   assign rsp_command_value  = value_ff;
   assign rsp_marks_activity = activity_ff;

endmodule

@@ hdl/ascii_line_command_decoder_core.sv @@
// ----------------------------------------------------------------------------
// ascii_line_command_decoder_core
// Parses newline-terminated ASCII command lines one byte at a time and emits
// one command per valid line, its argument clamped or flagged.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_rx_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_command_kind/_value/_marks_activity
//   csr      in         csr_write            csr_index, csr_data
//
// One byte per cycle while req_stall is low. After its newline is accepted, a
// result passes through the record queue and then into the executor's output
// register. req_stall rises only when the two-entry record queue is full.
// Reset restores line state and clamp limits.
// ----------------------------------------------------------------------------
module ascii_line_command_decoder_core
   import acd_pkg::*;
#(
   parameter int LINE_CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_command_kind,
   output logic [VALUE_W-1:0]   rsp_command_value,
   output logic                 rsp_marks_activity,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]   csr_data
);

   limits_type       limits_ff, limits_in;
   queue_status_type q_status;
   line_rec_type     push_rec;
   line_rec_type     head_rec;
   logic             push;
   logic             pop;
   logic             accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      limits_in = limits_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SOLDER_MIN: limits_in.solder_min = csr_data;
            CSR_SOLDER_MAX: limits_in.solder_max = csr_data;
            CSR_HOTAIR_MIN: limits_in.hotair_min = csr_data;
            CSR_HOTAIR_MAX: limits_in.hotair_max = csr_data;
            default: limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.solder_min <= SOLDER_MIN_RST;
         limits_ff.solder_max <= SOLDER_MAX_RST;
         limits_ff.hotair_min <= HOTAIR_MIN_RST;
         limits_ff.hotair_max <= HOTAIR_MAX_RST;
      end else begin
         limits_ff <= limits_in;
      end
   end

   acd_front #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .push     (push),
      .push_rec (push_rec)
   );

   acd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .status   (q_status),
      .head_rec (head_rec)
   );

   acd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .rec_valid          (q_status.not_empty),
      .rec                (head_rec),
      .limits             (limits_ff),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_command_kind   (rsp_command_kind),
      .rsp_command_value  (rsp_command_value),
      .rsp_marks_activity (rsp_marks_activity)
   );

endmodule

@@ hdl/acd_checker.sv @@
// ----------------------------------------------------------------------------
// acd_checker
// Port-level checks of the command decoder: held results and the value and
// activity ranges that each command kind allows.
// ----------------------------------------------------------------------------
module acd_checker
   import acd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [KIND_W-1:0]  rsp_command_kind,
   input logic [VALUE_W-1:0] rsp_command_value,
   input logic               rsp_marks_activity
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command_kind) &&
      $stable(rsp_command_value) && $stable(rsp_marks_activity))
      else $error("stalled result changed");

   a_fan_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command_kind == KIND_FAN) |-> rsp_command_value <= FAN_MAX)
      else $error("fan value above 255");

   a_flag_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_command_kind == KIND_POWER) ||
                    (rsp_command_kind == KIND_STATION)) |-> rsp_command_value <= 10'd1)
      else $error("flag value not 0 or 1");

   a_no_arg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_command_kind == KIND_BOOST) ||
                    (rsp_command_kind == KIND_STATUS) ||
                    (rsp_command_kind == KIND_PING)) |-> rsp_command_value == '0)
      else $error("value nonzero for argument-free command");

   a_activity : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_marks_activity == (rsp_command_kind <= KIND_BOOST))
      else $error("activity mark does not match command kind");

endmodule

bind ascii_line_command_decoder_core acd_checker u_acd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_command_kind   (rsp_command_kind),
   .rsp_command_value  (rsp_command_value),
   .rsp_marks_activity (rsp_marks_activity)
);
